FILE: hdl/mlai_pkg.sv
// Shared types and constants for the multi-axis linear interpolator.
package mlai_pkg;

  localparam int AXES      = 4;
  localparam int POS_W     = 16;   // position, target, axis speed
  localparam int STEP_W    = 14;   // step count and step index
  localparam int GAIN_W    = 10;
  localparam int TICK_W    = 10;
  localparam int ACC_W     = 36;   // gain * vmax * tick_ms
  localparam int NUM_W     = 34;   // distance * 256000
  localparam int Q_W       = 16;   // quotient bits out of the divider
  localparam int MB_W      = 14;   // multiplier operand, one bit per cycle
  localparam int CNT_W     = 5;
  localparam int NUM_SHIFT = 8;    // 256000 = 1000 << 8

  localparam logic [MB_W-1:0] DIST_MULT = 14'd1000;

  localparam logic [CNT_W-1:0] MUL_LAST = 5'd14;
  localparam logic [CNT_W-1:0] DIV_LAST = 5'd16;

  // APB register map, word addressed
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;
  localparam logic [IDX_W-1:0] REG_TICK_MS = 3'd0;
  localparam logic [IDX_W-1:0] REG_VMAX0   = 3'd1;

  localparam logic [TICK_W-1:0] TICK_RST = 10'd50;
  localparam logic [POS_W-1:0]  VMAX_RST = 16'd32768;

  typedef enum logic [2:0] {
    LN_HOLD,
    LN_MUL_START,
    LN_MUL_STEP,
    LN_SAVE_NUM,
    LN_DIV_START,
    LN_DIV_STEP
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     a_from_acc;  // multiplicand is the previous product
    logic     load_div;    // load division: saved numerator over product
  } lane_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L_NUM,
    ST_L_SAVE,
    ST_L_GV,
    ST_L_GVT,
    ST_L_DIV,
    ST_L_DONE,
    ST_T_MUL,
    ST_T_DIV,
    ST_EMIT
  } state_t;

endpackage

FILE: hdl/multi_axis_linear_interpolator.sv
// Four-axis coordinated linear move planner. A load transaction (req_type 0)
// latches targets, start positions and speed gain, then works out per axis
// floor(|goal-now|*256000/(gain*vmax*tick_ms)) clamped to [1, MAX_STEPS] and
// keeps the largest as the move length; it gives no result. Each tick
// transaction (req_type 1) while a move is running gives one result with all
// axes at start + delta*(i+1)/steps, truncated toward zero; the final step
// gives the exact targets with last_step set. A tick while idle is dropped.
// A load runs three multiplies, a save step, a divide and a step that picks
// the longest axis; a tick runs a multiply, a divide and the emit step, and
// the final step goes straight to emit. Each multiply is a load step plus 14
// shift-add bit steps and each divide a load step plus 16 restoring bit steps,
// one bit per cycle, all axes working in parallel. One transaction is in work
// at a time; a result waits in the output register while the next is taken,
// and the emit state stalls for as long as the previous result is still
// unaccepted.
// Configuration goes over APB: tick_ms at 0x00, vmax_axis0..3 at 0x04..0x10.
module multi_axis_linear_interpolator #(
  parameter int MAX_STEPS = 10000
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mlai_pkg::ADDR_W-1:0]   paddr,
  input  logic [mlai_pkg::DATA_W-1:0]   pwdata,
  output logic [mlai_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [mlai_pkg::GAIN_W-1:0]   in_speed_gain,
  input  logic [mlai_pkg::POS_W-1:0]    in_goal0,
  input  logic [mlai_pkg::POS_W-1:0]    in_goal1,
  input  logic [mlai_pkg::POS_W-1:0]    in_goal2,
  input  logic [mlai_pkg::POS_W-1:0]    in_goal3,
  input  logic [mlai_pkg::POS_W-1:0]    in_now0,
  input  logic [mlai_pkg::POS_W-1:0]    in_now1,
  input  logic [mlai_pkg::POS_W-1:0]    in_now2,
  input  logic [mlai_pkg::POS_W-1:0]    in_now3,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mlai_pkg::POS_W-1:0]    out_cmd0,
  output logic [mlai_pkg::POS_W-1:0]    out_cmd1,
  output logic [mlai_pkg::POS_W-1:0]    out_cmd2,
  output logic [mlai_pkg::POS_W-1:0]    out_cmd3,
  output logic [mlai_pkg::STEP_W-1:0]   out_step_index,
  output logic                          out_last_step
);

  localparam logic [mlai_pkg::STEP_W-1:0] MaxSteps = mlai_pkg::STEP_W'(MAX_STEPS);

  // configuration
  logic [mlai_pkg::TICK_W-1:0] tick_ms;
  logic [mlai_pkg::POS_W-1:0]  vmax [mlai_pkg::AXES];

  // port fields gathered per axis
  logic [mlai_pkg::POS_W-1:0] goal_in [mlai_pkg::AXES];
  logic [mlai_pkg::POS_W-1:0] now_in  [mlai_pkg::AXES];

  // sequencer
  mlai_pkg::state_t           state_r, state_nxt;
  logic [mlai_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  mlai_pkg::lane_ctrl_t       lctrl;
  logic [mlai_pkg::MB_W-1:0]  mul_b;
  logic                       a_vmax;
  logic                       in_acc, tick_last, emit_go, mul_done, div_done;

  // move state
  logic [mlai_pkg::GAIN_W-1:0] gain_r;
  logic [mlai_pkg::POS_W-1:0]  start_r [mlai_pkg::AXES];
  logic [mlai_pkg::POS_W-1:0]  end_r   [mlai_pkg::AXES];
  logic [mlai_pkg::POS_W-1:0]  dmag_r  [mlai_pkg::AXES];
  logic                        dneg_r  [mlai_pkg::AXES];
  logic [mlai_pkg::STEP_W-1:0] total_r, step_r;
  logic                        moving_r, last_r;

  // lane results
  logic [mlai_pkg::POS_W-1:0]  mul_a [mlai_pkg::AXES];
  logic [mlai_pkg::Q_W-1:0]    quo   [mlai_pkg::AXES];
  logic                        ovf   [mlai_pkg::AXES];
  logic [mlai_pkg::STEP_W-1:0] nsteps [mlai_pkg::AXES];
  logic [mlai_pkg::STEP_W-1:0] longest;

  // output register
  logic                        out_valid_r;
  logic [mlai_pkg::POS_W-1:0]  cmd_r [mlai_pkg::AXES];
  logic [mlai_pkg::STEP_W-1:0] idx_r;
  logic                        lastf_r;

  assign goal_in[0] = in_goal0;
  assign goal_in[1] = in_goal1;
  assign goal_in[2] = in_goal2;
  assign goal_in[3] = in_goal3;
  assign now_in[0]  = in_now0;
  assign now_in[1]  = in_now1;
  assign now_in[2]  = in_now2;
  assign now_in[3]  = in_now3;

  mlai_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tick_ms (tick_ms),
    .vmax    (vmax)
  );

  assign in_ready  = rst_n && (state_r == mlai_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  // last step when i+1 reaches the move length
  assign tick_last = ({1'b0, step_r} + 15'd1) >= {1'b0, total_r};
  assign mul_done  = (cnt_r == mlai_pkg::MUL_LAST);
  assign div_done  = (cnt_r == mlai_pkg::DIV_LAST);
  assign emit_go   = (state_r == mlai_pkg::ST_EMIT) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlai_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_req_type) begin
            state_nxt = mlai_pkg::ST_L_NUM;
          end else if (moving_r) begin
            state_nxt = tick_last ? mlai_pkg::ST_EMIT : mlai_pkg::ST_T_MUL;
          end
        end
      end
      mlai_pkg::ST_L_NUM:  if (mul_done) state_nxt = mlai_pkg::ST_L_SAVE;
      mlai_pkg::ST_L_SAVE: state_nxt = mlai_pkg::ST_L_GV;
      mlai_pkg::ST_L_GV:   if (mul_done) state_nxt = mlai_pkg::ST_L_GVT;
      mlai_pkg::ST_L_GVT:  if (mul_done) state_nxt = mlai_pkg::ST_L_DIV;
      mlai_pkg::ST_L_DIV:  if (div_done) state_nxt = mlai_pkg::ST_L_DONE;
      mlai_pkg::ST_L_DONE: state_nxt = mlai_pkg::ST_IDLE;
      mlai_pkg::ST_T_MUL:  if (mul_done) state_nxt = mlai_pkg::ST_T_DIV;
      mlai_pkg::ST_T_DIV:  if (div_done) state_nxt = mlai_pkg::ST_EMIT;
      mlai_pkg::ST_EMIT:   if (emit_go) state_nxt = mlai_pkg::ST_IDLE;
      default:             state_nxt = mlai_pkg::ST_IDLE;
    endcase
  end

  // bit counter restarts on every state change
  assign cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;

  // lane control
  always_comb begin
    lctrl  = '{op: mlai_pkg::LN_HOLD, a_from_acc: 1'b0, load_div: 1'b0};
    mul_b  = '0;
    a_vmax = 1'b0;
    unique case (state_r)
      mlai_pkg::ST_L_NUM: begin
        // distance * 1000
        lctrl.op = (cnt_r == '0) ? mlai_pkg::LN_MUL_START : mlai_pkg::LN_MUL_STEP;
        mul_b    = mlai_pkg::DIST_MULT;
      end
      mlai_pkg::ST_L_SAVE: begin
        lctrl.op = mlai_pkg::LN_SAVE_NUM;
      end
      mlai_pkg::ST_L_GV: begin
        // vmax * gain
        lctrl.op = (cnt_r == '0) ? mlai_pkg::LN_MUL_START : mlai_pkg::LN_MUL_STEP;
        mul_b    = mlai_pkg::MB_W'(gain_r);
        a_vmax   = 1'b1;
      end
      mlai_pkg::ST_L_GVT: begin
        // (vmax * gain) * tick_ms
        lctrl.op         = (cnt_r == '0) ? mlai_pkg::LN_MUL_START : mlai_pkg::LN_MUL_STEP;
        lctrl.a_from_acc = 1'b1;
        mul_b            = mlai_pkg::MB_W'(tick_ms);
      end
      mlai_pkg::ST_L_DIV: begin
        lctrl.op       = (cnt_r == '0) ? mlai_pkg::LN_DIV_START : mlai_pkg::LN_DIV_STEP;
        lctrl.load_div = 1'b1;
      end
      mlai_pkg::ST_T_MUL: begin
        // |delta| * (i+1)
        lctrl.op = (cnt_r == '0) ? mlai_pkg::LN_MUL_START : mlai_pkg::LN_MUL_STEP;
        mul_b    = step_r + 1'b1;
      end
      mlai_pkg::ST_T_DIV: begin
        lctrl.op = (cnt_r == '0) ? mlai_pkg::LN_DIV_START : mlai_pkg::LN_DIV_STEP;
      end
      mlai_pkg::ST_IDLE, mlai_pkg::ST_L_DONE, mlai_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < mlai_pkg::AXES; k++) begin : g_lane
    assign mul_a[k] = a_vmax ? vmax[k] : dmag_r[k];

    mlai_lane u_lane (
      .clk     (clk),
      .ctrl    (lctrl),
      .mul_a   (mul_a[k]),
      .mul_b   (mul_b),
      .den_ext (total_r),
      .quo     (quo[k]),
      .ovf     (ovf[k])
    );

    // clamp to [1, MAX_STEPS]; a zero divisor shows up as overflow
    always_comb begin
      if (ovf[k] || (quo[k] > mlai_pkg::Q_W'(MaxSteps))) begin
        nsteps[k] = MaxSteps;
      end else if (quo[k] == '0) begin
        nsteps[k] = mlai_pkg::STEP_W'(1);
      end else begin
        nsteps[k] = quo[k][mlai_pkg::STEP_W-1:0];
      end
    end
  end

  always_comb begin
    longest = mlai_pkg::STEP_W'(1);
    for (int k = 0; k < mlai_pkg::AXES; k++) begin
      if (nsteps[k] > longest) begin
        longest = nsteps[k];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlai_pkg::ST_IDLE;
      cnt_r       <= '0;
      moving_r    <= 1'b0;
      step_r      <= '0;
      total_r     <= mlai_pkg::STEP_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (in_acc && !in_req_type) begin
        // a load replaces any move in progress
        moving_r <= 1'b1;
        step_r   <= '0;
      end
      if (state_r == mlai_pkg::ST_L_DONE) begin
        total_r <= longest;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          moving_r <= 1'b0;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // move data and result payload
  always_ff @(posedge clk) begin
    if (in_acc && !in_req_type) begin
      gain_r <= in_speed_gain;
      for (int k = 0; k < mlai_pkg::AXES; k++) begin
        start_r[k] <= now_in[k];
        end_r[k]   <= goal_in[k];
        dneg_r[k]  <= goal_in[k] < now_in[k];
        dmag_r[k]  <= (goal_in[k] < now_in[k]) ? now_in[k] - goal_in[k]
                                                : goal_in[k] - now_in[k];
      end
    end
    if (in_acc && in_req_type) begin
      last_r <= tick_last;
    end
    if (emit_go) begin
      for (int k = 0; k < mlai_pkg::AXES; k++) begin
        if (last_r) begin
          cmd_r[k] <= end_r[k];
        end else if (dneg_r[k]) begin
          cmd_r[k] <= start_r[k] - quo[k];
        end else begin
          cmd_r[k] <= start_r[k] + quo[k];
        end
      end
      idx_r   <= step_r;
      lastf_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cmd0       = cmd_r[0];
  assign out_cmd1       = cmd_r[1];
  assign out_cmd2       = cmd_r[2];
  assign out_cmd3       = cmd_r[3];
  assign out_step_index = idx_r;
  assign out_last_step  = lastf_r;

endmodule

FILE: hdl/mlai_regs.sv
// APB configuration registers: tick interval and per-axis top speed.
module mlai_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mlai_pkg::ADDR_W-1:0]     paddr,
  input  logic [mlai_pkg::DATA_W-1:0]     pwdata,
  output logic [mlai_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  output logic [mlai_pkg::TICK_W-1:0]     tick_ms,
  output logic [mlai_pkg::POS_W-1:0]      vmax [mlai_pkg::AXES]
);

  logic [mlai_pkg::TICK_W-1:0] tick_r;
  logic [mlai_pkg::POS_W-1:0]  vmax_r [mlai_pkg::AXES];
  logic [mlai_pkg::IDX_W-1:0]  idx;
  logic                        wr;

  assign idx    = paddr[mlai_pkg::ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= mlai_pkg::TICK_RST;
      for (int k = 0; k < mlai_pkg::AXES; k++) begin
        vmax_r[k] <= mlai_pkg::VMAX_RST;
      end
    end else if (wr) begin
      if (idx == mlai_pkg::REG_TICK_MS) begin
        tick_r <= pwdata[mlai_pkg::TICK_W-1:0];
      end
      for (int k = 0; k < mlai_pkg::AXES; k++) begin
        if (idx == mlai_pkg::REG_VMAX0 + mlai_pkg::IDX_W'(k)) begin
          vmax_r[k] <= pwdata[mlai_pkg::POS_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == mlai_pkg::REG_TICK_MS) begin
      prdata = mlai_pkg::DATA_W'(tick_r);
    end
    for (int k = 0; k < mlai_pkg::AXES; k++) begin
      if (idx == mlai_pkg::REG_VMAX0 + mlai_pkg::IDX_W'(k)) begin
        prdata = mlai_pkg::DATA_W'(vmax_r[k]);
      end
    end
  end

  assign tick_ms = tick_r;
  assign vmax    = vmax_r;

endmodule

FILE: hdl/mlai_lane.sv
// One axis lane: bit-serial shift-add multiplier and restoring divider.
module mlai_lane (
  input  logic                         clk,
  input  mlai_pkg::lane_ctrl_t         ctrl,
  input  logic [mlai_pkg::POS_W-1:0]   mul_a,
  input  logic [mlai_pkg::MB_W-1:0]    mul_b,
  input  logic [mlai_pkg::STEP_W-1:0]  den_ext,
  output logic [mlai_pkg::Q_W-1:0]     quo,
  output logic                         ovf
);

  localparam int DSH_W = mlai_pkg::ACC_W + mlai_pkg::Q_W - 1;
  localparam int OVF_W = mlai_pkg::ACC_W + mlai_pkg::Q_W;

  logic [mlai_pkg::ACC_W-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [mlai_pkg::MB_W-1:0]  mplier_r, mplier_nxt;
  logic [mlai_pkg::NUM_W-1:0] num_r, num_nxt, rem_r, rem_nxt;
  logic [DSH_W-1:0]           dsh_r, dsh_nxt;
  logic [mlai_pkg::Q_W-1:0]   q_r, q_nxt;
  logic                       ovf_r, ovf_nxt;

  logic [mlai_pkg::ACC_W-1:0] den;
  logic [mlai_pkg::NUM_W-1:0] num_sel;
  logic [DSH_W-1:0]           rem_ext, diff;
  logic                       take;

  assign den     = ctrl.load_div ? acc_r : mlai_pkg::ACC_W'(den_ext);
  assign num_sel = ctrl.load_div ? num_r : acc_r[mlai_pkg::NUM_W-1:0];
  assign rem_ext = DSH_W'(rem_r);
  assign diff    = rem_ext - dsh_r;
  assign take    = rem_ext >= dsh_r;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    dsh_nxt    = dsh_r;
    q_nxt      = q_r;
    ovf_nxt    = ovf_r;
    unique case (ctrl.op)
      mlai_pkg::LN_HOLD: begin
      end
      mlai_pkg::LN_MUL_START: begin
        acc_nxt    = '0;
        mcand_nxt  = ctrl.a_from_acc ? acc_r : mlai_pkg::ACC_W'(mul_a);
        mplier_nxt = mul_b;
      end
      mlai_pkg::LN_MUL_STEP: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
      end
      mlai_pkg::LN_SAVE_NUM: begin
        num_nxt = mlai_pkg::NUM_W'(acc_r) << mlai_pkg::NUM_SHIFT;
      end
      mlai_pkg::LN_DIV_START: begin
        rem_nxt = num_sel;
        dsh_nxt = {den, {(mlai_pkg::Q_W-1){1'b0}}};
        // quotient needs more than Q_W bits, or divisor is zero
        ovf_nxt = {{(OVF_W-mlai_pkg::NUM_W){1'b0}}, num_sel} >=
                  {den, {mlai_pkg::Q_W{1'b0}}};
        q_nxt   = '0;
      end
      mlai_pkg::LN_DIV_STEP: begin
        if (take) begin
          rem_nxt = diff[mlai_pkg::NUM_W-1:0];
        end
        q_nxt   = {q_r[mlai_pkg::Q_W-2:0], take};
        dsh_nxt = dsh_r >> 1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    dsh_r    <= dsh_nxt;
    q_r      <= q_nxt;
    ovf_r    <= ovf_nxt;
  end

  assign quo = q_r;
  assign ovf = ovf_r;

endmodule

FILE: hdl/mlai_checker.sv
// Port-level checks for the interpolator, bound to the top level.
module mlai_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_req_type,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mlai_pkg::POS_W-1:0]  out_cmd0,
  input logic [mlai_pkg::POS_W-1:0]  out_cmd1,
  input logic [mlai_pkg::POS_W-1:0]  out_cmd2,
  input logic [mlai_pkg::POS_W-1:0]  out_cmd3,
  input logic [mlai_pkg::STEP_W-1:0] out_step_index,
  input logic                        out_last_step
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cmd0) && $stable(out_cmd1)
      && $stable(out_cmd2) && $stable(out_cmd3) && $stable(out_step_index)
      && $stable(out_last_step))
    else $error("result changed while stalled");

  // a load keeps the block busy
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_req_type |=> !in_ready)
    else $error("input taken straight after a load");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_req_type |=> !$rose(out_valid))
    else $error("result raised by a load");

  // a new result comes out of a busy period
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised while idle");

endmodule

bind multi_axis_linear_interpolator mlai_checker u_mlai_checker (.*);
